/* src/ole_pkg.sv */
// Package for the ordered list engine: sizes, command and status codes,
// controller states and the command/status structs between controller and datapath.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ole_pkg;

    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int DATA_W   = 32;

    localparam logic [2:0] CMD_APPEND   = 3'd0;
    localparam logic [2:0] CMD_REM_TAIL = 3'd1;
    localparam logic [2:0] CMD_REM_VAL  = 3'd2;
    localparam logic [2:0] CMD_DUMP_FWD = 3'd3;
    localparam logic [2:0] CMD_DUMP_BWD = 3'd4;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_EMPTY     = 2'd1;
    localparam logic [1:0] STS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STS_FULL      = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_DUMP
    } state_t;

    typedef struct packed {
        logic       load;
        logic       fwd;
        logic       rd_en;
        logic       push;
        logic       shift;
        logic       cnt_dec;
        logic       out_en;
        logic [1:0] out_status;
        logic       out_item;
        logic       out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic scan_vld;
        logic hit;
        logic at_end;
    } dp_sts_t;

endpackage

`default_nettype wire

/* src/ordered_list_engine_core.sv */
// Ordered list engine, top level: command port, controller and datapath.
// Depends on ole_pkg, ole_ctrl and ole_dp.
// Append, remove-tail and any defined command on an empty list: result in the cycle after the transfer.
// Remove-value: search, then close up the gap, one entry a cycle; result in the first cycle idle.
// Dumps: one result a cycle; each entry passes the walk pointer, read and result registers.
// Results cannot be stalled. Reset (rst_n low, asynchronous) empties the list.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_engine_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [2:0]                        cmd,
    input  wire logic signed [ole_pkg::DATA_W-1:0] value,
    output logic                                   strobe,
    output logic [1:0]                             status,
    output logic signed [ole_pkg::DATA_W-1:0]      item,
    output logic                                   last
);

    ole_pkg::dp_cmd_t dp_cmd;
    ole_pkg::dp_sts_t sts;

    ole_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .sts    (sts),
        .busy   (busy),
        .dp_cmd (dp_cmd)
    );

    ole_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .value  (value),
        .dp_cmd (dp_cmd),
        .sts    (sts),
        .strobe (strobe),
        .status (status),
        .item   (item),
        .last   (last)
    );

`ifndef SYNTH
    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("dump result without last mark while engine idle");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (status != ole_pkg::STS_OK) |-> last)
        else $error("error status not on final result");

    a_item_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (item != '0) |-> (status == ole_pkg::STS_OK))
        else $error("non-zero item with error status");

    a_append_reply: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd == ole_pkg::CMD_APPEND) |=> strobe && last && !busy)
        else $error("append transfer without single reply");
`endif

endmodule

`default_nettype wire

/* src/ole_ctrl.sv */
// Controller for the ordered list engine: command decode and walk sequencing.
// Depends on ole_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ole_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [2:0]       cmd,
    input  wire ole_pkg::dp_sts_t sts,
    output logic                  busy,
    output ole_pkg::dp_cmd_t      dp_cmd
);

    ole_pkg::state_t state_reg;
    ole_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ole_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ole_pkg::S_IDLE:
            begin
                if (start && !sts.empty)
                begin
                    case (cmd)
                        ole_pkg::CMD_REM_VAL:  state_next = ole_pkg::S_SEARCH;
                        ole_pkg::CMD_DUMP_FWD,
                        ole_pkg::CMD_DUMP_BWD: state_next = ole_pkg::S_DUMP;
                        default:               state_next = ole_pkg::S_IDLE;
                    endcase
                end
            end
            ole_pkg::S_SEARCH:
            begin
                if (sts.hit)
                begin
                    state_next = sts.at_end ? ole_pkg::S_IDLE : ole_pkg::S_SHIFT;
                end
                else if (sts.scan_vld && sts.at_end)
                begin
                    state_next = ole_pkg::S_IDLE;
                end
            end
            ole_pkg::S_SHIFT:
            begin
                if (sts.at_end)
                begin
                    state_next = ole_pkg::S_IDLE;
                end
            end
            ole_pkg::S_DUMP:
            begin
                if (sts.scan_vld && sts.at_end)
                begin
                    state_next = ole_pkg::S_IDLE;
                end
            end
            default: state_next = ole_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        dp_cmd = '0;
        dp_cmd.out_status = ole_pkg::STS_OK;
        busy = (state_reg != ole_pkg::S_IDLE);
        case (state_reg)
            ole_pkg::S_IDLE:
            begin
                if (start)
                begin
                    case (cmd)
                        ole_pkg::CMD_APPEND:
                        begin
                            dp_cmd.out_en   = 1'b1;
                            dp_cmd.out_last = 1'b1;
                            if (sts.full)
                            begin
                                dp_cmd.out_status = ole_pkg::STS_FULL;
                            end
                            else
                            begin
                                dp_cmd.push = 1'b1;
                            end
                        end
                        ole_pkg::CMD_REM_TAIL:
                        begin
                            dp_cmd.out_en   = 1'b1;
                            dp_cmd.out_last = 1'b1;
                            if (sts.empty)
                            begin
                                dp_cmd.out_status = ole_pkg::STS_EMPTY;
                            end
                            else
                            begin
                                dp_cmd.cnt_dec = 1'b1;
                            end
                        end
                        ole_pkg::CMD_REM_VAL,
                        ole_pkg::CMD_DUMP_FWD,
                        ole_pkg::CMD_DUMP_BWD:
                        begin
                            if (sts.empty)
                            begin
                                dp_cmd.out_en     = 1'b1;
                                dp_cmd.out_last   = 1'b1;
                                dp_cmd.out_status = ole_pkg::STS_EMPTY;
                            end
                            else
                            begin
                                dp_cmd.load = 1'b1;
                                dp_cmd.fwd  = (cmd != ole_pkg::CMD_DUMP_BWD);
                            end
                        end
                        default:
                        begin
                            dp_cmd.load = 1'b0;
                        end
                    endcase
                end
            end
            ole_pkg::S_SEARCH:
            begin
                dp_cmd.rd_en = 1'b1;
                if (sts.hit)
                begin
                    if (sts.at_end)
                    begin
                        dp_cmd.cnt_dec  = 1'b1;
                        dp_cmd.out_en   = 1'b1;
                        dp_cmd.out_last = 1'b1;
                    end
                end
                else if (sts.scan_vld && sts.at_end)
                begin
                    dp_cmd.out_en     = 1'b1;
                    dp_cmd.out_last   = 1'b1;
                    dp_cmd.out_status = ole_pkg::STS_NOT_FOUND;
                end
            end
            ole_pkg::S_SHIFT:
            begin
                dp_cmd.rd_en = 1'b1;
                dp_cmd.shift = 1'b1;
                if (sts.at_end)
                begin
                    dp_cmd.cnt_dec  = 1'b1;
                    dp_cmd.out_en   = 1'b1;
                    dp_cmd.out_last = 1'b1;
                end
            end
            ole_pkg::S_DUMP:
            begin
                dp_cmd.rd_en = 1'b1;
                if (sts.scan_vld)
                begin
                    dp_cmd.out_en   = 1'b1;
                    dp_cmd.out_item = 1'b1;
                    dp_cmd.out_last = sts.at_end;
                end
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/ole_dp.sv */
// Datapath for the ordered list engine: entry memory, fill count, walk pointers
// and the registered result ports. Depends on ole_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ole_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic signed [ole_pkg::DATA_W-1:0] value,
    input  wire ole_pkg::dp_cmd_t              dp_cmd,
    output ole_pkg::dp_sts_t                   sts,
    output logic                               strobe,
    output logic [1:0]                         status,
    output logic signed [ole_pkg::DATA_W-1:0]  item,
    output logic                               last
);

    logic [ole_pkg::DATA_W-1:0] mem [ole_pkg::CAPACITY];

    logic [ole_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [ole_pkg::CNT_W-1:0]  idx_reg, idx_next;
    logic [ole_pkg::CNT_W-1:0]  pos_reg, pos_next;
    logic                       fwd_reg, fwd_next;
    logic                       scan_vld_reg;
    logic [ole_pkg::DATA_W-1:0] val_reg;
    logic [ole_pkg::DATA_W-1:0] rd_data_reg;
    logic                       strobe_reg;
    logic [1:0]                 status_reg;
    logic [ole_pkg::DATA_W-1:0] item_reg;
    logic                       last_reg;

    logic [ole_pkg::CNT_W-1:0]  count_m1;
    logic [ole_pkg::CNT_W-1:0]  pos_m1;
    logic                       wr_en;
    logic [ole_pkg::ADDR_W-1:0] wr_addr;
    logic [ole_pkg::DATA_W-1:0] wr_data;

    assign count_m1 = count_reg - ole_pkg::CNT_W'(1);
    assign pos_m1   = pos_reg - ole_pkg::CNT_W'(1);

    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        fwd_next   = fwd_reg;
        if (dp_cmd.push)
        begin
            count_next = count_reg + ole_pkg::CNT_W'(1);
        end
        else if (dp_cmd.cnt_dec)
        begin
            count_next = count_m1;
        end
        if (dp_cmd.load)
        begin
            fwd_next = dp_cmd.fwd;
            idx_next = dp_cmd.fwd ? '0 : count_m1;
        end
        else if (dp_cmd.rd_en)
        begin
            pos_next = idx_reg;
            idx_next = fwd_reg ? (idx_reg + ole_pkg::CNT_W'(1))
                               : (idx_reg - ole_pkg::CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            idx_reg      <= '0;
            pos_reg      <= '0;
            fwd_reg      <= 1'b1;
            scan_vld_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            pos_reg      <= pos_next;
            fwd_reg      <= fwd_next;
            scan_vld_reg <= dp_cmd.rd_en;
            strobe_reg   <= dp_cmd.out_en;
        end
    end

    // write port: append at the tail, or close up one slot towards the head
    assign wr_en   = dp_cmd.push || dp_cmd.shift;
    assign wr_addr = dp_cmd.shift ? pos_m1[ole_pkg::ADDR_W-1:0]
                                  : count_reg[ole_pkg::ADDR_W-1:0];
    assign wr_data = dp_cmd.shift ? rd_data_reg : value;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (dp_cmd.rd_en)
        begin
            rd_data_reg <= mem[idx_reg[ole_pkg::ADDR_W-1:0]];
        end
        if (dp_cmd.load)
        begin
            val_reg <= value;
        end
        if (dp_cmd.out_en)
        begin
            status_reg <= dp_cmd.out_status;
            item_reg   <= dp_cmd.out_item ? rd_data_reg : '0;
            last_reg   <= dp_cmd.out_last;
        end
    end

    always_comb
    begin
        sts.empty    = (count_reg == '0);
        sts.full     = (count_reg == ole_pkg::CNT_W'(ole_pkg::CAPACITY));
        sts.scan_vld = scan_vld_reg;
        sts.hit      = scan_vld_reg && (rd_data_reg == val_reg);
        sts.at_end   = fwd_reg ? (pos_reg == count_m1) : (pos_reg == '0);
    end

    assign strobe = strobe_reg;
    assign status = status_reg;
    assign item   = item_reg;
    assign last   = last_reg;

endmodule

`default_nettype wire
